### hdl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Types and constants shared by the palindromic tree builder modules.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 26;
  localparam int NODES    = MAX_LEN + 3;
  localparam int NODE_W   = 11;
  localparam int POS_W    = 11;
  localparam int LET_AW   = 10;
  localparam int SYM_W    = 5;
  localparam int LEN_W    = 12;
  localparam int SPAN_W   = 10;
  localparam int CNT_W    = 11;
  localparam int ROW_W    = ALPHABET * NODE_W;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_NODE  = 2'd2;
  localparam logic [1:0] ST_FINALIZED = 2'd3;

  localparam logic [NODE_W-1:0] ROOT_IMAG  = NODE_W'(1);
  localparam logic [NODE_W-1:0] ROOT_EMPTY = NODE_W'(2);

  typedef struct packed {
    logic [1:0]        op;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] sel;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]       link;
    logic signed [LEN_W-1:0] len;
    logic [CNT_W-1:0]        depth;
    logic [SPAN_W-1:0]       fs;
    logic [SPAN_W-1:0]       fe;
  } node_rec_t;

endpackage

### hdl/ptb_front.sv
// ----------------------------------------------------------------------------
// ptb_front
// Input side: accepts items, clamps the letter code, queues them for the engine.
// ----------------------------------------------------------------------------
module ptb_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ptb_pkg::IN_DATA_W-1:0]    s_tdata,  // symbol, node_sel
  input  logic [1:0]                       s_tuser,  // operation
  input  logic                             hold,
  output ptb_pkg::item_t                   item,
  output logic                             item_valid,
  input  logic                             item_ready
);

  ptb_pkg::item_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  ptb_pkg::item_t incoming;

  always_comb begin
    incoming.op  = s_tuser;
    incoming.sel = s_tdata[15:5];
    if (s_tdata[4:0] >= ptb_pkg::SYM_W'(ptb_pkg::ALPHABET)) begin
      incoming.sym = ptb_pkg::SYM_W'(ptb_pkg::ALPHABET - 1);
    end else begin
      incoming.sym = s_tdata[4:0];
    end
  end

  assign s_tready   = (count != 2'd2) && !hold;
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/ptb_back.sv
// ----------------------------------------------------------------------------
// ptb_back
// Tree engine: node memories, suffix link walk, finalize sweep, result register.
// ----------------------------------------------------------------------------
module ptb_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ptb_pkg::item_t                    item,
  input  logic                              item_valid,
  output logic                              item_ready,
  output logic                              clearing,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ptb_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                        m_tuser
);

  localparam int NW = ptb_pkg::NODE_W;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_HOP_A  = 5'd2;
  localparam logic [4:0] S_HOP_B  = 5'd3;
  localparam logic [4:0] S_HOP_C  = 5'd4;
  localparam logic [4:0] S_TROW   = 5'd5;
  localparam logic [4:0] S_TROW_Q = 5'd6;
  localparam logic [4:0] S_XROW   = 5'd7;
  localparam logic [4:0] S_XROW_Q = 5'd8;
  localparam logic [4:0] S_LNK_A  = 5'd9;
  localparam logic [4:0] S_LNK_B  = 5'd10;
  localparam logic [4:0] S_OCC_A  = 5'd11;
  localparam logic [4:0] S_OCC_B  = 5'd12;
  localparam logic [4:0] S_RES_A  = 5'd13;
  localparam logic [4:0] S_OUT    = 5'd14;
  localparam logic [4:0] S_FIN_A  = 5'd15;
  localparam logic [4:0] S_FIN_B  = 5'd16;
  localparam logic [4:0] S_FIN_C  = 5'd17;
  localparam logic [4:0] S_FIN_Z1 = 5'd18;
  localparam logic [4:0] S_FIN_Z2 = 5'd19;

  ptb_pkg::node_rec_t           rec_mem [ptb_pkg::NODES];
  logic [ptb_pkg::ROW_W-1:0]    child_mem [ptb_pkg::NODES];
  logic [ptb_pkg::CNT_W-1:0]    occ_mem [ptb_pkg::NODES];
  logic [ptb_pkg::SYM_W-1:0]    letters [ptb_pkg::MAX_LEN];

  logic [4:0]                   state;
  logic [NW-1:0]                clr_idx;
  logic                         clr_report;
  logic [ptb_pkg::POS_W-1:0]    position;
  logic [NW-1:0]                cur;
  logic [NW-1:0]                last_node;
  logic                         finalized;
  logic [ptb_pkg::POS_W-1:0]    p;
  logic [ptb_pkg::SYM_W-1:0]    sym;
  logic [NW-1:0]                walk;
  logic                         phase;
  logic [NW-1:0]                hop_link;
  logic                         q_neg;
  logic                         q_eq;
  logic [NW-1:0]                t_node;
  logic signed [ptb_pkg::LEN_W-1:0] t_len;
  logic [NW-1:0]                t_link;
  logic [ptb_pkg::ROW_W-1:0]    row_t;
  logic [NW-1:0]                k_link;
  logic [NW-1:0]                rep_node;
  logic                         res_ok;
  logic                         res_created;
  logic [1:0]                   res_status;
  logic [NW-1:0]                fi;
  logic [NW-1:0]                fl;
  logic [ptb_pkg::CNT_W-1:0]    occ_i;

  ptb_pkg::node_rec_t           rec_q;
  logic [ptb_pkg::ROW_W-1:0]    row_q;
  logic [ptb_pkg::CNT_W-1:0]    occ_q;
  logic [ptb_pkg::SYM_W-1:0]    lt_q;

  logic [NW-1:0]                rec_ra;
  logic [NW-1:0]                row_ra;
  logic [NW-1:0]                occ_ra;
  logic                         rec_we;
  logic [NW-1:0]                rec_wa;
  ptb_pkg::node_rec_t           rec_wd;
  logic                         row_we;
  logic [NW-1:0]                row_wa;
  logic [ptb_pkg::ROW_W-1:0]    row_wd;
  logic                         occ_we;
  logic [NW-1:0]                occ_wa;
  logic [ptb_pkg::CNT_W-1:0]    occ_wd;
  logic                         let_we;
  logic signed [12:0]           q;
  logic [NW-1:0]                entry;
  logic signed [ptb_pkg::LEN_W-1:0] new_len;
  logic [ptb_pkg::LEN_W-1:0]    first_s;
  logic                         out_free;
  logic                         fit;
  logic [ptb_pkg::OUT_DATA_W-1:0] out_word;

  assign clearing   = (state == S_CLR);
  assign item_ready = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign let_we     = (state == S_IDLE) && item_valid && (item.op == ptb_pkg::OP_APPEND) &&
                      !finalized && (position < ptb_pkg::POS_W'(ptb_pkg::MAX_LEN));

  assign q       = $signed({2'b00, p}) - 13'(rec_q.len) - 13'sd1;
  assign entry   = row_q[int'(sym) * NW +: NW];
  assign new_len = t_len + 12'sd2;
  assign first_s = {1'b0, p} + 12'd1 - new_len;
  assign fit     = !q_neg && (q_eq || (lt_q == sym));

  always_comb begin
    rec_ra = cur;
    row_ra = t_node;
    occ_ra = rep_node;
    unique case (state) inside
      S_HOP_A: rec_ra = walk;
      S_LNK_A: rec_ra = k_link;
      S_FIN_A: rec_ra = fi;
      S_RES_A, S_OUT: rec_ra = rep_node;
      default: rec_ra = cur;
    endcase
    unique case (state)
      S_XROW:  row_ra = walk;
      default: row_ra = t_node;
    endcase
    unique case (state)
      S_OCC_A: occ_ra = cur;
      S_FIN_A: occ_ra = fi;
      S_FIN_B: occ_ra = rec_q.link;
      default: occ_ra = rep_node;
    endcase
  end

  always_comb begin
    rec_we = 1'b0;
    rec_wa = clr_idx;
    rec_wd = '0;
    row_we = 1'b0;
    row_wa = clr_idx;
    row_wd = '0;
    occ_we = 1'b0;
    occ_wa = clr_idx;
    occ_wd = '0;
    unique case (state)
      S_CLR: begin
        rec_we = 1'b1;
        row_we = 1'b1;
        occ_we = 1'b1;
        if (clr_idx == ptb_pkg::ROOT_IMAG) begin
          rec_wd.link = ptb_pkg::ROOT_IMAG;
          rec_wd.len  = -12'sd1;
        end else if (clr_idx == ptb_pkg::ROOT_EMPTY) begin
          rec_wd.link = ptb_pkg::ROOT_IMAG;
        end
      end
      S_LNK_B: begin
        rec_we       = 1'b1;
        rec_wa       = last_node + NW'(1);
        rec_wd.link  = k_link;
        rec_wd.len   = new_len;
        rec_wd.depth = rec_q.depth + ptb_pkg::CNT_W'(1);
        rec_wd.fs    = first_s[ptb_pkg::SPAN_W-1:0];
        rec_wd.fe    = p[ptb_pkg::SPAN_W-1:0];
        row_we       = 1'b1;
        row_wa       = t_node;
        row_wd       = row_t;
        row_wd[int'(sym) * NW +: NW] = last_node + NW'(1);
        occ_we       = 1'b1;
        occ_wa       = last_node + NW'(1);
        occ_wd       = ptb_pkg::CNT_W'(1);
      end
      S_OCC_B: begin
        occ_we = 1'b1;
        occ_wa = cur;
        occ_wd = occ_q + ptb_pkg::CNT_W'(1);
      end
      S_FIN_C: begin
        occ_we = 1'b1;
        occ_wa = fl;
        occ_wd = occ_q + occ_i;
      end
      S_FIN_Z1: begin
        occ_we = 1'b1;
        occ_wa = ptb_pkg::ROOT_IMAG;
      end
      S_FIN_Z2: begin
        occ_we = 1'b1;
        occ_wa = ptb_pkg::ROOT_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word        = '0;
    out_word[76:66] = last_node;
    if (res_ok) begin
      out_word[10:0]  = rep_node;
      out_word[11]    = res_created;
      out_word[23:12] = rec_q.len;
      out_word[33:24] = rec_q.fs;
      out_word[43:34] = rec_q.fe;
      out_word[54:44] = rec_q.depth;
      out_word[65:55] = occ_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      child_mem[row_wa] <= row_wd;
    end
    row_q <= child_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_q <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (let_we) begin
      letters[position[ptb_pkg::LET_AW-1:0]] <= item.sym;
    end
    lt_q <= letters[q[ptb_pkg::LET_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      m_tvalid   <= 1'b0;
      position   <= '0;
      cur        <= ptb_pkg::ROOT_EMPTY;
      last_node  <= ptb_pkg::ROOT_EMPTY;
      finalized  <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(ptb_pkg::NODES - 1)) begin
            position  <= '0;
            cur       <= ptb_pkg::ROOT_EMPTY;
            last_node <= ptb_pkg::ROOT_EMPTY;
            finalized <= 1'b0;
            if (clr_report) begin
              res_ok     <= 1'b0;
              res_status <= ptb_pkg::ST_OK;
              state      <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          res_created <= 1'b0;
          if (item_valid) begin
            unique case (item.op)
              ptb_pkg::OP_APPEND: begin
                res_ok <= 1'b0;
                if (finalized) begin
                  res_status <= ptb_pkg::ST_FINALIZED;
                  state      <= S_OUT;
                end else if (position >= ptb_pkg::POS_W'(ptb_pkg::MAX_LEN)) begin
                  res_status <= ptb_pkg::ST_FULL;
                  state      <= S_OUT;
                end else begin
                  res_status <= ptb_pkg::ST_OK;
                  p          <= position;
                  position   <= position + ptb_pkg::POS_W'(1);
                  sym        <= item.sym;
                  walk       <= cur;
                  phase      <= 1'b0;
                  state      <= S_HOP_A;
                end
              end
              ptb_pkg::OP_FINALIZE: begin
                res_ok <= 1'b0;
                if (finalized) begin
                  res_status <= ptb_pkg::ST_FINALIZED;
                  state      <= S_OUT;
                end else begin
                  res_status <= ptb_pkg::ST_OK;
                  fi         <= last_node;
                  state      <= S_FIN_A;
                end
              end
              ptb_pkg::OP_READ: begin
                if (item.sel == '0 || item.sel > last_node) begin
                  res_ok     <= 1'b0;
                  res_status <= ptb_pkg::ST_BAD_NODE;
                  state      <= S_OUT;
                end else begin
                  rep_node   <= item.sel;
                  res_ok     <= 1'b1;
                  res_status <= ptb_pkg::ST_OK;
                  state      <= S_RES_A;
                end
              end
              ptb_pkg::OP_CLEAR: begin
                clr_idx    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_HOP_A: state <= S_HOP_B;
        S_HOP_B: begin
          q_neg    <= q[12];
          q_eq     <= (rec_q.len == -12'sd1);
          hop_link <= rec_q.link;
          if (!phase) begin
            t_len  <= rec_q.len;
            t_link <= rec_q.link;
          end
          state <= S_HOP_C;
        end
        S_HOP_C: begin
          if (fit) begin
            if (!phase) begin
              t_node <= walk;
              state  <= S_TROW;
            end else begin
              state <= S_XROW;
            end
          end else begin
            walk  <= hop_link;
            state <= S_HOP_A;
          end
        end
        S_TROW: state <= S_TROW_Q;
        S_TROW_Q: begin
          row_t <= row_q;
          if (entry != '0) begin
            cur   <= entry;
            state <= S_OCC_A;
          end else if (last_node >= NW'(ptb_pkg::NODES - 1)) begin
            state <= S_OCC_A;
          end else if (new_len == 12'sd1) begin
            k_link <= ptb_pkg::ROOT_EMPTY;
            state  <= S_LNK_A;
          end else begin
            walk  <= t_link;
            phase <= 1'b1;
            state <= S_HOP_A;
          end
        end
        S_XROW: state <= S_XROW_Q;
        S_XROW_Q: begin
          k_link <= (entry == '0) ? ptb_pkg::ROOT_EMPTY : entry;
          state  <= S_LNK_A;
        end
        S_LNK_A: state <= S_LNK_B;
        S_LNK_B: begin
          last_node   <= last_node + NW'(1);
          cur         <= last_node + NW'(1);
          rep_node    <= last_node + NW'(1);
          res_created <= 1'b1;
          res_ok      <= 1'b1;
          state       <= S_RES_A;
        end
        S_OCC_A: state <= S_OCC_B;
        S_OCC_B: begin
          rep_node <= cur;
          res_ok   <= 1'b1;
          state    <= S_RES_A;
        end
        S_RES_A: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            m_tuser <= res_status;
            m_tdata <= out_word;
            state   <= S_IDLE;
          end
        end
        S_FIN_A: begin
          if (fi < NW'(3)) begin
            state <= S_FIN_Z1;
          end else begin
            state <= S_FIN_B;
          end
        end
        S_FIN_B: begin
          occ_i <= occ_q;
          fl    <= rec_q.link;
          state <= S_FIN_C;
        end
        S_FIN_C: begin
          fi    <= fi - NW'(1);
          state <= S_FIN_A;
        end
        S_FIN_Z1: state <= S_FIN_Z2;
        S_FIN_Z2: begin
          finalized <= 1'b1;
          state     <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/palindromic_tree_builder_core.sv
// ----------------------------------------------------------------------------
// palindromic_tree_builder_core
// Eertree builder over a letter stream with node read, finalize and clear.
// ----------------------------------------------------------------------------
// One request per s_ transfer: s_tuser is the operation, s_tdata carries the
// letter code and the node index. Each request gives exactly one m_ result,
// m_tuser being the status and m_tdata the node fields and node count.
// A two-entry queue sits in front of the engine, so requests keep flowing
// while a result waits in the output register.
// Work per request in the engine:
//   append: a suffix link walk from the current node, then a second walk
//           from the found node's link for a new node's suffix link
//   read: a lookup of the selected node; error results: straight to the output
//   finalize: a sweep over the created nodes, last to first, then the roots
//   clear: a pass over all node rows, one node row after another
// After reset the same clearing pass runs with s_tready low and
// gives no result. When m_tready is held low the result holds, the engine
// stops at its next result and the queue then fills and drops s_tready.
module palindromic_tree_builder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ptb_pkg::IN_DATA_W-1:0]    s_tdata,  // symbol, node_sel
  input  logic [1:0]                       s_tuser,  // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ptb_pkg::OUT_DATA_W-1:0]   m_tdata,  // node_id, created, pal_length,
                                                     // pal_start, pal_end, suffix_depth,
                                                     // occurrences, node_count
  output logic [1:0]                       m_tuser   // status
);

  ptb_pkg::item_t item;
  logic           item_valid;
  logic           item_ready;
  logic           clearing;

  ptb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .hold       (clearing),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  ptb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .clearing   (clearing),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

### hdl/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port level checks for the palindromic tree builder.
// ----------------------------------------------------------------------------
module ptb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ptb_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic [1:0]                       m_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ptb_pkg::ST_OK) |-> (m_tdata[65:0] == '0))
    else $error("error result carries node fields");

  a_node_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[76:66] >= 11'd2) && (m_tdata[10:0] <= m_tdata[76:66]))
    else $error("node index beyond node count");

endmodule

bind palindromic_tree_builder_core ptb_checker u_ptb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### test/palindromic_tree_builder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_core_tb
// Stream testbench for the eertree builder: directed corner requests, then
// random letter runs over small alphabets with reads and finalize, one run
// past the string limit, random idling on both sides and one long output
// stall. Every result is checked field by field against a predicted tree.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_core_tb;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [1:0]                 status;
    logic [ptb_pkg::NODE_W-1:0] node_id;
    logic                       created;
    logic [ptb_pkg::LEN_W-1:0]  pal_length;
    logic [ptb_pkg::SPAN_W-1:0] pal_start;
    logic [ptb_pkg::SPAN_W-1:0] pal_end;
    logic [ptb_pkg::CNT_W-1:0]  suffix_depth;
    logic [ptb_pkg::CNT_W-1:0]  occurrences;
    logic [ptb_pkg::NODE_W-1:0] node_count;
  } node_rpt_t;

  class tree_scoreboard;
    int letters [ptb_pkg::MAX_LEN];
    int pos, cur, last_n, fin;
    int child [ptb_pkg::NODES][ptb_pkg::ALPHABET];
    int link [ptb_pkg::NODES];
    int len [ptb_pkg::NODES];
    int depth [ptb_pkg::NODES];
    int occ [ptb_pkg::NODES];
    int fs [ptb_pkg::NODES];
    int fe [ptb_pkg::NODES];
    node_rpt_t pending [$];
    int errors;
    int n_app, n_fin, n_rd, n_clr, n_full;

    function void restart();
      foreach (child[i, j]) child[i][j] = 0;
      for (int i = 0; i < ptb_pkg::NODES; i++) begin
        link[i] = 0; len[i] = 0; depth[i] = 0; occ[i] = 0; fs[i] = 0; fe[i] = 0;
      end
      len[1] = -1; link[1] = 1; link[2] = 1;
      pos = 0; cur = 2; last_n = 2; fin = 0;
    endfunction

    function bit fits(int node, int p, int c);
      int q;
      q = p - len[node] - 1;
      if (q < 0 || q >= ptb_pkg::MAX_LEN) return 0;
      return letters[q] == c;
    endfunction

    function node_rpt_t report(int st, int node, int made);
      node_rpt_t r;
      r = '{default: '0};
      r.status = st[1:0];
      r.node_count = last_n[ptb_pkg::NODE_W-1:0];
      if (st != ptb_pkg::ST_OK || node == 0 || node >= ptb_pkg::NODES) return r;
      r.node_id = node[ptb_pkg::NODE_W-1:0];
      r.created = made[0];
      r.pal_length = len[node][ptb_pkg::LEN_W-1:0];
      r.pal_start = fs[node][ptb_pkg::SPAN_W-1:0];
      r.pal_end = fe[node][ptb_pkg::SPAN_W-1:0];
      r.suffix_depth = depth[node][ptb_pkg::CNT_W-1:0];
      r.occurrences = occ[node][ptb_pkg::CNT_W-1:0];
      return r;
    endfunction

    function void note(logic [1:0] op, logic [ptb_pkg::SYM_W-1:0] sym_in,
                       logic [ptb_pkg::NODE_W-1:0] sel);
      int p, t, x, k, made, sym;
      node_rpt_t r;
      r = report(ptb_pkg::ST_OK, 0, 0);
      case (op)
        ptb_pkg::OP_APPEND: begin
          n_app++;
          if (fin) r = report(ptb_pkg::ST_FINALIZED, 0, 0);
          else if (pos >= ptb_pkg::MAX_LEN) begin
            r = report(ptb_pkg::ST_FULL, 0, 0);
            n_full++;
          end else begin
            sym = (sym_in >= ptb_pkg::ALPHABET) ? ptb_pkg::ALPHABET - 1 : int'(sym_in);
            made = 0;
            p = pos;
            letters[p] = sym;
            t = cur;
            while (!fits(t, p, sym)) t = link[t];
            x = link[t];
            while (!fits(x, p, sym)) x = link[x];
            if (child[t][sym] == 0 && last_n + 1 < ptb_pkg::NODES) begin
              last_n++;
              k = last_n;
              child[t][sym] = k;
              len[k] = len[t] + 2;
              link[k] = (len[k] == 1) ? 2 : child[x][sym];
              if (link[k] == 0 || link[k] >= ptb_pkg::NODES) link[k] = 2;
              depth[k] = 1 + depth[link[k]];
              fs[k] = p + 1 - len[k];
              fe[k] = p;
              made = 1;
            end
            if (child[t][sym] != 0) cur = child[t][sym];
            occ[cur]++;
            pos = p + 1;
            r = report(ptb_pkg::ST_OK, cur, made);
          end
        end
        ptb_pkg::OP_FINALIZE: begin
          n_fin++;
          if (fin) r = report(ptb_pkg::ST_FINALIZED, 0, 0);
          else begin
            for (int i = last_n; i >= 3; i--) occ[link[i]] += occ[i];
            occ[1] = 0; occ[2] = 0; fin = 1;
            r = report(ptb_pkg::ST_OK, 0, 0);
          end
        end
        ptb_pkg::OP_READ: begin
          n_rd++;
          if (sel == 0 || sel > last_n) r = report(ptb_pkg::ST_BAD_NODE, 0, 0);
          else r = report(ptb_pkg::ST_OK, int'(sel), 0);
        end
        default: begin
          n_clr++;
          restart();
          r = report(ptb_pkg::ST_OK, 0, 0);
        end
      endcase
      pending.insert(pending.size(), r);
    endfunction

    function void check(logic [1:0] st, logic [ptb_pkg::OUT_DATA_W-1:0] d);
      node_rpt_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status exp %0d act %0d", e.status, st); errors++;
      end
      if (d[10:0] !== e.node_id) begin
        $error("node_id exp %0d act %0d", e.node_id, d[10:0]); errors++;
      end
      if (d[11] !== e.created) begin
        $error("created exp %0d act %0d", e.created, d[11]); errors++;
      end
      if (d[23:12] !== e.pal_length) begin
        $error("pal_length exp %0d act %0d", $signed(e.pal_length), $signed(d[23:12]));
        errors++;
      end
      if (d[33:24] !== e.pal_start) begin
        $error("pal_start exp %0d act %0d", e.pal_start, d[33:24]); errors++;
      end
      if (d[43:34] !== e.pal_end) begin
        $error("pal_end exp %0d act %0d", e.pal_end, d[43:34]); errors++;
      end
      if (d[54:44] !== e.suffix_depth) begin
        $error("suffix_depth exp %0d act %0d", e.suffix_depth, d[54:44]); errors++;
      end
      if (d[65:55] !== e.occurrences) begin
        $error("occurrences exp %0d act %0d", e.occurrences, d[65:55]); errors++;
      end
      if (d[76:66] !== e.node_count) begin
        $error("node_count exp %0d act %0d", e.node_count, d[76:66]); errors++;
      end
      if (d[79:77] !== 3'b000) begin
        $error("padding exp 0 act %0d", d[79:77]); errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [ptb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [ptb_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0]                     m_tuser;

  tree_scoreboard sb = new();
  int src_idle = 0;
  int snk_idle = 0;
  int quiet = 0;
  int results = 0;
  int hold_left = 0;
  bit hold_done = 0;

  palindromic_tree_builder_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sink with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check(m_tuser, m_tdata);
      results++;
    end
    if (!hold_done && results == 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [ptb_pkg::SYM_W-1:0] sym,
                      logic [ptb_pkg::NODE_W-1:0] sel);
    if ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sel, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(op, sym, sel);
  endtask

  task automatic read_any();
    if ($urandom_range(0, 9) == 0) send(ptb_pkg::OP_READ, 5'($urandom_range(0, 31)),
                                        11'($urandom_range(0, 2047)));
    else send(ptb_pkg::OP_READ, 5'($urandom_range(0, 31)),
              11'($urandom_range(0, sb.last_n + 2)));
  endtask

  task automatic letter_run(int n, int hi, bit close);
    send(ptb_pkg::OP_CLEAR, 5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 19) == 0)
          send(ptb_pkg::OP_APPEND, 5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)));
        else
          send(ptb_pkg::OP_APPEND, 5'($urandom_range(0, hi)), 11'($urandom_range(0, 2047)));
      end else read_any();
    end
    if (close) begin
      send(ptb_pkg::OP_FINALIZE, 5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)));
      repeat ($urandom_range(2, 6)) read_any();
      if ($urandom_range(0, 1)) send(ptb_pkg::OP_FINALIZE, 5'd0, 11'd0);
      send(ptb_pkg::OP_APPEND, 5'($urandom_range(0, 31)), 11'd0);
    end
  endtask

  initial begin
    sb.restart();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send(ptb_pkg::OP_READ, 5'd0, 11'd0);
    send(ptb_pkg::OP_READ, 5'd0, 11'd1);
    send(ptb_pkg::OP_READ, 5'd0, 11'd2);
    send(ptb_pkg::OP_READ, 5'd0, 11'd3);
    send(ptb_pkg::OP_APPEND, 5'd0, 11'd0);
    send(ptb_pkg::OP_APPEND, 5'd25, 11'h7ff);
    send(ptb_pkg::OP_APPEND, 5'd31, 11'd0);
    send(ptb_pkg::OP_APPEND, 5'd25, 11'd0);
    send(ptb_pkg::OP_APPEND, 5'd0, 11'd0);
    send(ptb_pkg::OP_APPEND, 5'd0, 11'd0);
    send(ptb_pkg::OP_READ, 5'd31, 11'd5);
    send(ptb_pkg::OP_READ, 5'd0, 11'd7);
    send(ptb_pkg::OP_READ, 5'd0, 11'h7ff);
    send(ptb_pkg::OP_FINALIZE, 5'd0, 11'd0);
    send(ptb_pkg::OP_READ, 5'd0, 11'd3);
    send(ptb_pkg::OP_READ, 5'd0, 11'd2);
    send(ptb_pkg::OP_FINALIZE, 5'd0, 11'd0);
    send(ptb_pkg::OP_APPEND, 5'd1, 11'd0);
    send(ptb_pkg::OP_CLEAR, 5'd0, 11'd0);
    send(ptb_pkg::OP_READ, 5'd0, 11'd3);
    send(ptb_pkg::OP_FINALIZE, 5'd0, 11'd0);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 6 : (ph == 1) ? 51 : 0;
      snk_idle = (ph == 0) ? 51 : (ph == 1) ? 6 : 0;
      if (ph < 2) begin
        repeat (12) letter_run($urandom_range(10, 50), $urandom_range(1, 3),
                               $urandom_range(0, 1));
        letter_run(30, 25, 1);
      end else begin
        // past the string limit
        send(ptb_pkg::OP_CLEAR, 5'd0, 11'd0);
        for (int i = 0; i < ptb_pkg::MAX_LEN + 6; i++)
          send(ptb_pkg::OP_APPEND, 5'($urandom_range(0, 1)), 11'd0);
        repeat (8) read_any();
        send(ptb_pkg::OP_READ, 5'd0, 11'(sb.last_n));
        send(ptb_pkg::OP_FINALIZE, 5'd0, 11'd0);
        repeat (8) read_any();
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d appends (%0d past full), %0d finalizes, %0d reads, %0d clears",
             sb.n_app, sb.n_full, sb.n_fin, sb.n_rd, sb.n_clr);
    $display("%0d results checked over three idling phases and a long output stall",
             results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
